### src/siph_pkg.sv
// ----------------------------------------------------------------------------
// siph_pkg
// Types, constants and the SipRound function shared by the SipHash core.
// ----------------------------------------------------------------------------
package siph_pkg;

    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;

    localparam logic [63:0] FINAL_PAD = 64'h00000000000000ff;

    localparam int WORD_W  = 64;
    localparam int VALID_W = 4;
    localparam int COUNT_W = 8;
    localparam int TDATA_W = 72;

    typedef logic [0:0] t_cfg_addr;
    localparam t_cfg_addr CFG_KEY_LOW  = 1'b0;
    localparam t_cfg_addr CFG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // word taken from the input this cycle
        logic round;      // update lanes with one SipRound
        logic pre;        // xor new block into v3 before the round
        logic sel_block;  // new block is the length block, not the input word
        logic post_m;     // xor block into v0 after the round
        logic post_ff;    // xor pad into v2 after the round
        logic emit;       // load hash into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_short;   // last word with fewer than 8 valid bytes
        logic out_free;   // output register can take a hash this cycle
    } t_dp_sts;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
        rotl = (x << s) | (x >> (64 - s));
    endfunction

    function automatic t_lanes sip_round(input t_lanes l);
        logic [63:0] a0, a1, a2, a3;
        a0 = l.v0 + l.v1;
        a1 = rotl(l.v1, 13) ^ a0;
        a0 = rotl(a0, 32);
        a2 = l.v2 + l.v3;
        a3 = rotl(l.v3, 16) ^ a2;
        a0 = a0 + a3;
        a3 = rotl(a3, 21) ^ a0;
        a2 = a2 + a1;
        a1 = rotl(a1, 17) ^ a2;
        a2 = rotl(a2, 32);
        sip_round = '{v0: a0, v1: a1, v2: a2, v3: a3};
    endfunction

endpackage

### src/siph_ctrl.sv
// ----------------------------------------------------------------------------
// siph_ctrl
// Sequencer: steps the shared round unit through word, length-block and
// finishing rounds.
// ----------------------------------------------------------------------------
module siph_ctrl #(
    parameter int ROUNDS_PER_WORD = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  siph_pkg::t_dp_sts i_sts,
    output siph_pkg::t_dp_cmd o_cmd
);

    localparam int MAXR = (ROUNDS_PER_WORD > FINAL_ROUNDS) ? ROUNDS_PER_WORD : FINAL_ROUNDS;
    localparam int CW   = (MAXR > 1) ? $clog2(MAXR) : 1;
    localparam logic [CW-1:0] W_LAST = CW'(ROUNDS_PER_WORD - 1);
    localparam logic [CW-1:0] F_LAST = CW'(FINAL_ROUNDS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WORD = 4'b0010,
        S_BLK  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_rnd, n_rnd;
    logic          r_last, n_last;
    logic          accepting;

    assign o_in_ready = (r_state == S_IDLE);
    assign accepting  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accepting) begin
                    // first round of the new block runs in the accept cycle
                    o_cmd.accept = 1'b1;
                    o_cmd.round  = 1'b1;
                    o_cmd.pre    = 1'b1;
                    n_last       = i_in_last && !i_sts.in_short;
                    if (ROUNDS_PER_WORD == 1) begin
                        o_cmd.post_m = 1'b1;
                        n_rnd        = '0;
                        if (i_sts.in_short) begin
                            o_cmd.post_ff = 1'b1;
                            n_state       = S_FIN;
                        end else if (i_in_last) begin
                            n_state = S_BLK;
                        end
                    end else begin
                        n_rnd   = CW'(1);
                        n_state = i_sts.in_short ? S_BLK : S_WORD;
                    end
                end
            end
            S_WORD: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + CW'(1);
                if (r_rnd == W_LAST) begin
                    o_cmd.post_m = 1'b1;
                    n_rnd        = '0;
                    n_state      = r_last ? S_BLK : S_IDLE;
                end
            end
            S_BLK: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + CW'(1);
                if (r_rnd == '0) begin
                    o_cmd.pre       = 1'b1;
                    o_cmd.sel_block = 1'b1;
                end
                if (r_rnd == W_LAST) begin
                    o_cmd.post_m  = 1'b1;
                    o_cmd.post_ff = 1'b1;
                    n_rnd         = '0;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (r_rnd != F_LAST) begin
                    o_cmd.round = 1'b1;
                    n_rnd       = r_rnd + CW'(1);
                end else if (i_sts.out_free) begin
                    // hold the last round until the output register drains
                    o_cmd.round = 1'b1;
                    o_cmd.emit  = 1'b1;
                    n_rnd       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_rnd   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_last  <= n_last;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("hash emitted while output register busy");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accepting && i_in_last) |=> !o_in_ready)
        else $error("input taken before final rounds of a message");

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= CW'(MAXR - 1))
        else $error("round counter out of range");

    a_state_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule

### src/siph_dp.sv
// ----------------------------------------------------------------------------
// siph_dp
// Datapath: key registers, four SipHash lanes on one round unit, byte count,
// and the output register.
// ----------------------------------------------------------------------------
module siph_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  siph_pkg::t_cfg_addr  i_cfg_addr,
    input  logic [63:0]          i_cfg_wdata,
    input  logic [63:0]          i_data_word,
    input  logic [3:0]           i_valid_bytes,
    input  logic                 i_last,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [63:0]          o_hash_value,
    input  siph_pkg::t_dp_cmd    i_cmd,
    output siph_pkg::t_dp_sts    o_sts
);

    logic [63:0]       r_key_low, r_key_high;
    siph_pkg::t_lanes  r_lanes;
    logic [63:0]       r_msg;
    logic [7:0]        r_count;
    logic              r_open;
    logic              r_ovalid;
    logic [63:0]       r_hash;

    siph_pkg::t_lanes  init_l, base_l, pre_l, rnd_l;
    logic              in_short;
    logic [63:0]       tail;
    logic [7:0]        base_count, count_add, count_new;
    logic [63:0]       m_next, m_use;

    assign in_short = i_last && (i_valid_bytes < 4'd8);

    // drop bytes beyond the valid count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            tail[8*b +: 8] = (4'(b) < i_valid_bytes) ? i_data_word[8*b +: 8] : 8'h00;
        end
    end

    assign base_count = r_open ? r_count : 8'd0;
    assign count_add  = in_short ? {4'd0, i_valid_bytes} : 8'd8;
    assign count_new  = base_count + count_add;

    always_comb begin
        if (i_cmd.sel_block)
            m_next = {r_count, 56'd0};
        else if (in_short)
            m_next = {count_new, tail[55:0]};
        else
            m_next = i_data_word;
    end
    assign m_use = i_cmd.pre ? m_next : r_msg;

    assign init_l = '{v0: siph_pkg::IV0 ^ r_key_low,  v1: siph_pkg::IV1 ^ r_key_high,
                      v2: siph_pkg::IV2 ^ r_key_low,  v3: siph_pkg::IV3 ^ r_key_high};

    always_comb begin
        base_l = (i_cmd.accept && !r_open) ? init_l : r_lanes;
        pre_l  = base_l;
        if (i_cmd.pre)
            pre_l.v3 = base_l.v3 ^ m_next;
        rnd_l = siph_pkg::sip_round(pre_l);
        if (i_cmd.post_m)
            rnd_l.v0 = rnd_l.v0 ^ m_use;
        if (i_cmd.post_ff)
            rnd_l.v2 = rnd_l.v2 ^ siph_pkg::FINAL_PAD;
    end

    assign o_sts.in_short = in_short;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    // config and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_open     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    siph_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                    siph_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.emit)
                r_open <= 1'b0;
            else if (i_cmd.accept)
                r_open <= 1'b1;
            if (i_cmd.emit)
                r_ovalid <= 1'b1;
            else if (i_out_ready)
                r_ovalid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.round)
            r_lanes <= rnd_l;
        if (i_cmd.pre)
            r_msg <= m_next;
        if (i_cmd.accept)
            r_count <= count_new;
        if (i_cmd.emit)
            r_hash <= rnd_l.v0 ^ rnd_l.v1 ^ rnd_l.v2 ^ rnd_l.v3;
    end

    assign o_out_valid  = r_ovalid;
    assign o_hash_value = r_hash;

endmodule

### src/siphash_word_stream_core.sv
// ----------------------------------------------------------------------------
// siphash_word_stream_core
// Keyed SipHash over a byte message streamed as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// One SipRound unit, shared over all phases, does one round per clock while a
// word is in work and sets the timing. A word that is not last gets
// ROUNDS_PER_WORD rounds; its first round runs in the cycle the word is taken.
// A last word with 0 to 7 valid bytes is merged with the length byte into one
// block; one with 8 or more is absorbed whole and a length block follows; then
// the finishing rounds run and the hash lands in the output register. The next
// message may start right after, while the hash still waits. If the previous
// hash has not been taken out, the last finishing round holds until it drains,
// and the word after it waits as long. The key registers are to be written
// through the config port between messages, which the block does not enforce;
// a message uses the key it saw on its first word. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module siphash_word_stream_core #(
    parameter int ROUNDS_PER_WORD = 2,
    parameter int FINAL_ROUNDS    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_we,
    input  siph_pkg::t_cfg_addr i_cfg_addr,
    input  logic [63:0]         i_cfg_wdata,
    // input words
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [71:0]         s_axis_tdata,  // [63:0] data_word, [67:64] valid_bytes
    input  logic                s_axis_tlast,
    // hash out
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata   // [63:0] hash_value
);

    siph_pkg::t_dp_cmd cmd;
    siph_pkg::t_dp_sts sts;

    siph_ctrl #(
        .ROUNDS_PER_WORD (ROUNDS_PER_WORD),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    siph_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_data_word   (s_axis_tdata[63:0]),
        .i_valid_bytes (s_axis_tdata[67:64]),
        .i_last        (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_hash_value  (m_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

### tb/siphash_word_stream_core_test.sv
// ----------------------------------------------------------------------------
// siphash_word_stream_core_test
// Streams byte messages as 64-bit words into the SipHash core and checks every
// hash against a SipHash-2-4 predictor or a published vector, under several
// keys, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module siphash_word_stream_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS_PER_WORD = 2;
    localparam int FINAL_ROUNDS    = 4;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 5000;
    localparam int PHASE_WORDS     = 160;
    localparam int NUM_PHASES      = 5;
    localparam int NUM_ROWS        = 18;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic        known;
        logic [63:0] hash;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    siph_pkg::t_cfg_addr i_cfg_addr;
    logic [63:0]         i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [71:0]         s_axis_tdata;  // [63:0] data_word, [67:64] valid_bytes
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;  // [63:0] hash_value

    siphash_word_stream_core #(
        .ROUNDS_PER_WORD(ROUNDS_PER_WORD),
        .FINAL_ROUNDS   (FINAL_ROUNDS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Directed words; key is 00..0f for these. Known hashes are the published
    // SipHash-2-4 vectors for the empty message and the single byte 00.
    t_stim_row dir_rows [NUM_ROWS] = '{
        '{ONES,                  4'd0,  1'b1, 1'b1, 64'h726fdb47dd0e0e31},
        '{64'hffff_ffff_ffff_ff00, 4'd1, 1'b1, 1'b1, 64'h74f839c593dc67fd},
        '{64'h0706050403020100,  4'd8,  1'b1, 1'b0, 64'h0},
        '{64'h0706050403020100,  4'd0,  1'b0, 1'b0, 64'h0},
        '{ONES,                  4'd15, 1'b0, 1'b0, 64'h0},
        '{64'h0,                 4'd7,  1'b1, 1'b0, 64'h0},
        '{ONES,                  4'd15, 1'b1, 1'b0, 64'h0},
        '{ONES,                  4'd9,  1'b1, 1'b0, 64'h0},
        '{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd12, 1'b1, 1'b0, 64'h0},
        '{64'h0,                 4'd0,  1'b1, 1'b0, 64'h0},
        '{ONES,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{ONES,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{ONES,                  4'd6,  1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd2, 1'b1, 1'b0, 64'h0},
        '{64'h0123456789abcdef,  4'd3,  1'b1, 1'b0, 64'h0},
        '{64'hfedcba9876543210,  4'd4,  1'b1, 1'b0, 64'h0},
        '{64'h0f1e2d3c4b5a6978,  4'd5,  1'b1, 1'b0, 64'h0}
    };

    // Predictor state
    logic [63:0] key_k0   = '0;
    logic [63:0] key_k1   = '0;
    logic [63:0] lane [4] = '{default: '0};
    logic [7:0]  len_byte = '0;
    bit          msg_open = 1'b0;

    logic [63:0] hash_q [$];
    int          err_count    = 0;
    int          stall_cycles = 0;
    int          burst_left;
    logic        drv_known;
    logic [63:0] drv_hash;
    int          sink_mode = 0;
    int          sink_hold = 0;

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned s);
        logic [127:0] dbl;
        dbl = {x, x} << s;
        return dbl[127:64];
    endfunction

    function automatic void lane_round();
        lane[0] = lane[0] + lane[1];
        lane[1] = rol64(lane[1], 13) ^ lane[0];
        lane[0] = rol64(lane[0], 32);
        lane[2] = lane[2] + lane[3];
        lane[3] = rol64(lane[3], 16) ^ lane[2];
        lane[0] = lane[0] + lane[3];
        lane[3] = rol64(lane[3], 21) ^ lane[0];
        lane[2] = lane[2] + lane[1];
        lane[1] = rol64(lane[1], 17) ^ lane[2];
        lane[2] = rol64(lane[2], 32);
    endfunction

    function automatic void absorb_block(input logic [63:0] m);
        lane[3] = lane[3] ^ m;
        repeat (ROUNDS_PER_WORD) lane_round();
        lane[0] = lane[0] ^ m;
    endfunction

    // Take one word into the running hash; returns 1 when it closes the message.
    function automatic bit hash_word(input logic [63:0] word, input logic [3:0] nb,
                                     input logic lst, output logic [63:0] hash);
        logic [63:0] tail;
        int unsigned n;
        hash = '0;
        tail = '0;
        if (!msg_open) begin
            lane[0]  = siph_pkg::IV0 ^ key_k0;
            lane[1]  = siph_pkg::IV1 ^ key_k1;
            lane[2]  = siph_pkg::IV2 ^ key_k0;
            lane[3]  = siph_pkg::IV3 ^ key_k1;
            len_byte = '0;
            msg_open = 1'b1;
        end
        if (!lst) begin
            absorb_block(word);
            len_byte = len_byte + 8'd8;
            return 1'b0;
        end
        n = (nb > 4'd8) ? 8 : nb;
        if (n == 8) begin
            absorb_block(word);
            len_byte = len_byte + 8'd8;
        end else if (n != 0) begin
            tail     = word & ((64'h1 << (8 * n)) - 64'h1);
            len_byte = len_byte + n[7:0];
        end
        absorb_block({len_byte, 56'h0} | tail);
        lane[2] = lane[2] ^ 64'hff;
        repeat (FINAL_ROUNDS) lane_round();
        hash     = lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
        msg_open = 1'b0;
        len_byte = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check hashes, track key writes, predict accepted words, watch for a hang.
    always @(posedge i_clk) begin : scoreboard
        logic [63:0] want;
        logic [63:0] pred;
        bit          busy;
        if (i_rst_n) begin
            busy = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                busy = 1'b1;
                if (hash_q.size() == 0) begin
                    report_mismatch("hash with none pending", m_axis_tdata, 64'h0);
                end else begin
                    want = hash_q.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("hash_value", m_axis_tdata, want);
                end
            end
            if (i_cfg_we) begin
                busy = 1'b1;
                if (i_cfg_addr == siph_pkg::CFG_KEY_LOW)
                    key_k0 = i_cfg_wdata;
                else
                    key_k1 = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                busy = 1'b1;
                if (hash_word(s_axis_tdata[63:0], s_axis_tdata[67:64], s_axis_tlast, pred))
                    hash_q.push_back(drv_known ? drv_hash : pred);
            end
            stall_cycles = busy ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $realtime,
                         stall_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver stalls: switch among steady, coin-flip, sparse and square-wave.
    always @(negedge i_clk) begin
        if (sink_hold == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_hold <= $urandom_range(20, 150);
        end else begin
            sink_hold <= sink_hold - 1;
        end
        case (sink_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_axis_tready <= sink_hold[3];
            end
        endcase
    end

    task automatic write_key(input siph_pkg::t_cfg_addr addr, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1);
        write_key(siph_pkg::CFG_KEY_LOW, k0);
        write_key(siph_pkg::CFG_KEY_HIGH, k1);
    endtask

    // Hold the word on the bus until the core takes it.
    task automatic push_word(input logic [63:0] data, input logic [3:0] nb,
                             input logic lst, input logic known, input logic [63:0] hash);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, nb, data};
        s_axis_tlast  <= lst;
        drv_known     <= known;
        drv_hash      <= hash;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Insert a gap between bursts; about a third of the bursts follow on directly.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(input logic [63:0] data, input logic [3:0] nb,
                               input logic lst);
        pace();
        push_word(data, nb, lst, 1'b0, 64'h0);
    endtask

    // Drop valid, wait for every pending hash, then let the round unit settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] rand_tail_bytes();
        return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
    endfunction

    function automatic int rand_body_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return $urandom_range(0, 3);
        if (pick < 94) return $urandom_range(4, 12);
        // long enough that the length byte may wrap
        return $urandom_range(30, 40);
    endfunction

    initial begin : stimulus
        logic [63:0] k0, k1;
        int sent;
        int body;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = siph_pkg::CFG_KEY_LOW;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        drv_known     = 1'b0;
        drv_hash      = '0;
        burst_left    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Keys straight out of reset
        push_word(64'h0, 4'd0, 1'b1, 1'b0, 64'h0);
        push_word(ONES, 4'd8, 1'b0, 1'b0, 64'h0);
        push_word(ONES, 4'd3, 1'b1, 1'b0, 64'h0);
        drain();

        set_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
        for (int r = 0; r < NUM_ROWS; r++) begin
            push_word(dir_rows[r].data, dir_rows[r].nbytes, dir_rows[r].last,
                      dir_rows[r].known, dir_rows[r].hash);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    k0 = 64'h0;
                    k1 = 64'h0;
                end
                1: begin
                    k0 = ONES;
                    k1 = ONES;
                end
                3: begin
                    k0 = ONES;
                    k1 = 64'h0;
                end
                default: begin
                    k0 = {$urandom, $urandom};
                    k1 = {$urandom, $urandom};
                end
            endcase
            set_keys(k0, k1);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                body = rand_body_len();
                for (int w = 0; w < body; w++) begin
                    send_random(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
                end
                send_random(rand_word(), rand_tail_bytes(), 1'b1);
                sent += body + 1;
            end
            // Leave a message open so the next key write lands mid-message.
            if (ph % 2 == 0 && ph != NUM_PHASES - 1) begin
                body = $urandom_range(1, 3);
                for (int w = 0; w < body; w++) begin
                    send_random(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
                end
            end
            drain();
        end

        if (hash_q.size() != 0)
            report_mismatch("hashes never delivered", 64'(hash_q.size()), 64'h0);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
